// ===== hdl/grid_2x2_pattern_match_assert.svh =====
// ----------------------------------------------------------------------------
// Grid 2x2 pattern match assertion macros
// Shared concurrent assertion forms used by the pattern match RTL.
// ----------------------------------------------------------------------------
`ifndef GRID_2X2_PATTERN_MATCH_ASSERT_SVH
`define GRID_2X2_PATTERN_MATCH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GPM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GPM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/gpm_pkg.sv =====
// ----------------------------------------------------------------------------
// Grid 2x2 pattern match package
// Sizes, register indexes and shared types of the pattern match block.
// ----------------------------------------------------------------------------
package gpm_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int COLOR_W    = 3;
   localparam int COORD_W    = 10;
   localparam int COUNT_W    = 20;
   localparam int CSR_DATA_W = 11;
   localparam int CSR_IDX_W  = 3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_TOP_LEFT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_TOP_RGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_BOT_LEFT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_BOT_RGHT = 3'd5;

   typedef struct packed {
      logic [COL_W-1:0]   last_col;
      logic [ROW_W-1:0]   last_row;
      logic [COLOR_W-1:0] pat_top_left;
      logic [COLOR_W-1:0] pat_top_right;
      logic [COLOR_W-1:0] pat_bottom_left;
      logic [COLOR_W-1:0] pat_bottom_right;
   } cfg_type;

endpackage

// ===== hdl/gpm_if.sv =====
// ----------------------------------------------------------------------------
// Grid 2x2 pattern match channels
// Valid/ready channels for the cell words and the result words.
// ----------------------------------------------------------------------------
interface gpm_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] cell_color;

   modport source (output valid, output cell_color, input ready);
   modport sink (input valid, input cell_color, output ready);
endinterface

interface gpm_rsp_if;
   logic        valid;
   logic        ready;
   logic        match_found;
   logic [9:0]  match_x;
   logic [9:0]  match_y;
   logic [19:0] match_count;
   logic        frame_end;

   modport source (output valid, output match_found, output match_x, output match_y,
                   output match_count, output frame_end, input ready);
   modport sink (input valid, input match_found, input match_x, input match_y,
                 input match_count, input frame_end, output ready);
endinterface

// ===== hdl/gpm_csr.sv =====
// ----------------------------------------------------------------------------
// Grid 2x2 pattern match configuration registers
// Holds frame size and pattern, and clamps the size to the supported range.
// ----------------------------------------------------------------------------
module gpm_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [gpm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gpm_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output gpm_pkg::cfg_type                   cfg
);
   import gpm_pkg::*;

   logic [CSR_DATA_W-1:0] width_ff;
   logic [CSR_DATA_W-1:0] height_ff;
   logic [COLOR_W-1:0]    pat_tl_ff;
   logic [COLOR_W-1:0]    pat_tr_ff;
   logic [COLOR_W-1:0]    pat_bl_ff;
   logic [COLOR_W-1:0]    pat_br_ff;
   logic [CSR_DATA_W-1:0] width_eff;
   logic [CSR_DATA_W-1:0] height_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CSR_DATA_W'(2);
         height_ff <= CSR_DATA_W'(2);
         pat_tl_ff <= '0;
         pat_tr_ff <= '0;
         pat_bl_ff <= '0;
         pat_br_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:   width_ff  <= csr_write_data;
            CSR_GRID_HEIGHT:  height_ff <= csr_write_data;
            CSR_PAT_TOP_LEFT: pat_tl_ff <= csr_write_data[COLOR_W-1:0];
            CSR_PAT_TOP_RGHT: pat_tr_ff <= csr_write_data[COLOR_W-1:0];
            CSR_PAT_BOT_LEFT: pat_bl_ff <= csr_write_data[COLOR_W-1:0];
            CSR_PAT_BOT_RGHT: pat_br_ff <= csr_write_data[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      priority if (width_ff < CSR_DATA_W'(2)) begin
         width_eff = CSR_DATA_W'(2);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         width_eff = CSR_DATA_W'(MAX_WIDTH);
      end else begin
         width_eff = width_ff;
      end
      priority if (height_ff < CSR_DATA_W'(2)) begin
         height_eff = CSR_DATA_W'(2);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         height_eff = CSR_DATA_W'(MAX_HEIGHT);
      end else begin
         height_eff = height_ff;
      end
   end

   assign cfg.last_col         = COL_W'(width_eff - CSR_DATA_W'(1));
   assign cfg.last_row         = ROW_W'(height_eff - CSR_DATA_W'(1));
   assign cfg.pat_top_left     = pat_tl_ff;
   assign cfg.pat_top_right    = pat_tr_ff;
   assign cfg.pat_bottom_left  = pat_bl_ff;
   assign cfg.pat_bottom_right = pat_br_ff;

endmodule

// ===== hdl/gpm_line_buffer.sv =====
// ----------------------------------------------------------------------------
// Grid 2x2 pattern match line buffer
// One-row memory of colors with a registered read and write-to-read bypass.
// ----------------------------------------------------------------------------
module gpm_line_buffer (
   input  logic                            clock,
   input  logic                            rd_en,
   input  logic [gpm_pkg::COL_W-1:0]       rd_addr,
   output logic [gpm_pkg::COLOR_W-1:0]     rd_data,
   input  logic                            wr_en,
   input  logic [gpm_pkg::COL_W-1:0]       wr_addr,
   input  logic [gpm_pkg::COLOR_W-1:0]     wr_data
);
   import gpm_pkg::*;

   logic [COLOR_W-1:0] mem_ff [MAX_WIDTH];
   logic [COLOR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // A read of the entry written in the same cycle returns the new word.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/grid_2x2_pattern_match.sv =====
// ----------------------------------------------------------------------------
// Grid 2x2 pattern match
// Sliding 2x2 window compare over a raster of color codes with match count.
// ----------------------------------------------------------------------------
// The block takes one cell word per clock in row-major order unless the result
// channel stalls, and returns one result word per cell. The accepting edge
// captures the cell and registers the read of the cell above from the line
// buffer, which has separate read and write ports. A later edge, taken once the
// output register is free or being emptied, compares the window and loads the
// output register. A stalled output holds one result while one more cell waits
// in the read stage, so full throughput resumes once the sink takes the word.
`include "grid_2x2_pattern_match_assert.svh"

module grid_2x2_pattern_match (
   input  logic                               clock,
   input  logic                               reset,
   gpm_req_if.sink                            req_chan,
   gpm_rsp_if.source                          rsp_chan,
   input  logic                               csr_write_enable,
   input  logic [gpm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gpm_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import gpm_pkg::*;

   cfg_type cfg;

   logic               accept;
   logic               a_move;
   logic               last_col;
   logic               last_row;
   logic               hit;
   logic [COLOR_W-1:0] above;
   logic [COUNT_W-1:0] count_in;

   logic [COL_W-1:0]   col_ff;
   logic [ROW_W-1:0]   row_ff;

   logic               a_valid_ff;
   logic [COLOR_W-1:0] a_color_ff;
   logic [COL_W-1:0]   a_col_ff;
   logic [ROW_W-1:0]   a_row_ff;
   logic               a_inner_ff;
   logic               a_last_ff;

   logic [COLOR_W-1:0] left_ff;
   logic [COLOR_W-1:0] upper_ff;
   logic [COUNT_W-1:0] count_ff;

   logic               out_valid_ff;
   logic               found_ff;
   logic [COORD_W-1:0] x_ff;
   logic [COORD_W-1:0] y_ff;
   logic [COUNT_W-1:0] count_out_ff;
   logic               end_ff;

   gpm_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   gpm_line_buffer u_line_buffer (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (above),
      .wr_en   (a_move),
      .wr_addr (a_col_ff),
      .wr_data (a_color_ff)
   );

   assign a_move         = a_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !a_valid_ff || a_move;
   assign accept         = req_chan.valid && req_chan.ready;

   assign last_col = col_ff >= cfg.last_col;
   assign last_row = row_ff >= cfg.last_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (last_col) begin
            col_ff <= '0;
            row_ff <= last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_ff <= col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (accept) begin
         a_valid_ff <= 1'b1;
      end else if (a_move) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_color_ff <= req_chan.cell_color;
         a_col_ff   <= col_ff;
         a_row_ff   <= row_ff;
         a_inner_ff <= (col_ff != '0) && (row_ff != '0);
         a_last_ff  <= last_col && last_row;
      end
   end

   assign hit = a_inner_ff &&
                (upper_ff == cfg.pat_top_left) &&
                (above == cfg.pat_top_right) &&
                (left_ff == cfg.pat_bottom_left) &&
                (a_color_ff == cfg.pat_bottom_right);

   assign count_in = (hit && (count_ff != COUNT_MAX)) ? count_ff + COUNT_W'(1) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= '0;
         upper_ff <= '0;
         count_ff <= '0;
      end else if (a_move) begin
         left_ff  <= a_color_ff;
         upper_ff <= above;
         count_ff <= a_last_ff ? '0 : count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (a_move) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (a_move) begin
         found_ff     <= hit;
         x_ff         <= hit ? COORD_W'(a_col_ff) : '0;
         y_ff         <= hit ? COORD_W'(a_row_ff) : '0;
         count_out_ff <= count_in;
         end_ff       <= a_last_ff;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.match_found = found_ff;
   assign rsp_chan.match_x     = x_ff;
   assign rsp_chan.match_y     = y_ff;
   assign rsp_chan.match_count = count_out_ff;
   assign rsp_chan.frame_end   = end_ff;

   `GPM_ASSERT_NEXT(frame_count_clear, clock, reset, a_move && a_last_ff, count_ff == '0, "Match count not cleared after the last cell of a frame.")
   `GPM_ASSERT_IMP(stall_only_when_full, clock, reset, !req_chan.ready, a_valid_ff && out_valid_ff && !rsp_chan.ready, "Input stalled while the pipeline has room.")
   `GPM_ASSERT_NEXT(move_loads_output, clock, reset, a_move, out_valid_ff, "Result word lost on its way to the output register.")
   `GPM_ASSERT_IMP(found_has_count, clock, reset, out_valid_ff && found_ff, count_out_ff != '0, "Match reported with a zero match count.")

endmodule

// ===== sim/grid_2x2_pattern_match_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid 2x2 pattern match checker
// Watches the cell, result and register ports of the block. It keeps its own
// line buffer, window and match count, works out the result word due for
// every accepted cell word, and compares each accepted result word with the
// oldest one due.
// ----------------------------------------------------------------------------
module grid_2x2_pattern_match_checker (
   input  logic                           clock,
   input  logic                           reset,
   gpm_req_if                             req_chan,
   gpm_rsp_if                             rsp_chan,
   input  logic                           csr_write_enable,
   input  logic [gpm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gpm_pkg::CSR_DATA_W-1:0] csr_write_data,
   output int                             mismatches,
   output int                             words_due
);
   import gpm_pkg::*;

   typedef struct packed {
      logic               match_found;
      logic [COORD_W-1:0] match_x;
      logic [COORD_W-1:0] match_y;
      logic [COUNT_W-1:0] match_count;
      logic               frame_end;
   } match_word_type;

   logic [CSR_DATA_W-1:0] width_reg;
   logic [CSR_DATA_W-1:0] height_reg;
   logic [COLOR_W-1:0]    pat_tl;
   logic [COLOR_W-1:0]    pat_tr;
   logic [COLOR_W-1:0]    pat_bl;
   logic [COLOR_W-1:0]    pat_br;

   logic [COLOR_W-1:0]    line_buf [MAX_WIDTH];
   logic [COLOR_W-1:0]    left_q;
   logic [COLOR_W-1:0]    upleft_q;
   logic [COL_W-1:0]      col_q;
   logic [ROW_W-1:0]      row_q;
   logic [COUNT_W:0]      frame_matches;

   match_word_type match_words_due [$];

   initial mismatches = 0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (mismatches < 40) begin
         $display("%0t ns mismatch: %s got %0d want %0d", $time, what, got, want);
      end
      mismatches++;
   endtask

   function automatic logic [CSR_DATA_W-1:0] clamp_size(input logic [CSR_DATA_W-1:0] raw,
                                                          input int lim);
      if (raw < 2) return CSR_DATA_W'(2);
      if (raw > lim) return CSR_DATA_W'(lim);
      return raw;
   endfunction

   // Closes the window at the current position and moves the raster on by one cell.
   function automatic match_word_type predict_window(input logic [COLOR_W-1:0] cur);
      logic [CSR_DATA_W-1:0] w;
      logic [CSR_DATA_W-1:0] h;
      logic [COLOR_W-1:0]    above;
      logic                  hit;
      logic                  at_last_col;
      logic                  at_last_row;
      match_word_type        word;
      w = clamp_size(width_reg, MAX_WIDTH);
      h = clamp_size(height_reg, MAX_HEIGHT);
      above = line_buf[col_q];
      hit = (col_q != '0) && (row_q != '0) && (upleft_q == pat_tl) && (above == pat_tr) &&
            (left_q == pat_bl) && (cur == pat_br);
      if (hit && frame_matches < COUNT_MAX) frame_matches = frame_matches + 1'b1;
      word.match_found = hit;
      word.match_x     = hit ? COORD_W'(col_q) : '0;
      word.match_y     = hit ? COORD_W'(row_q) : '0;
      word.match_count = frame_matches[COUNT_W-1:0];
      upleft_q = above;
      left_q = cur;
      line_buf[col_q] = cur;
      at_last_col = {1'b0, col_q} >= w - 1'b1;
      at_last_row = {1'b0, row_q} >= h - 1'b1;
      word.frame_end = at_last_col && at_last_row;
      if (at_last_col) begin
         col_q = '0;
         if (at_last_row) begin
            row_q = '0;
            frame_matches = '0;
         end else begin
            row_q = row_q + 1'b1;
         end
      end else begin
         col_q = col_q + 1'b1;
      end
      return word;
   endfunction

   always @(posedge clock) begin : watch_channels
      match_word_type want;
      match_word_type due;
      if (reset) begin
         width_reg = CSR_DATA_W'(2);
         height_reg = CSR_DATA_W'(2);
         pat_tl = '0;
         pat_tr = '0;
         pat_bl = '0;
         pat_br = '0;
         for (int i = 0; i < MAX_WIDTH; i++) line_buf[i] = '0;
         left_q = '0;
         upleft_q = '0;
         col_q = '0;
         row_q = '0;
         frame_matches = '0;
         match_words_due.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_GRID_WIDTH:   width_reg = csr_write_data;
               CSR_GRID_HEIGHT:  height_reg = csr_write_data;
               CSR_PAT_TOP_LEFT: pat_tl = csr_write_data[COLOR_W-1:0];
               CSR_PAT_TOP_RGHT: pat_tr = csr_write_data[COLOR_W-1:0];
               CSR_PAT_BOT_LEFT: pat_bl = csr_write_data[COLOR_W-1:0];
               CSR_PAT_BOT_RGHT: pat_br = csr_write_data[COLOR_W-1:0];
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready) begin
            due = predict_window(req_chan.cell_color);
            match_words_due.insert(match_words_due.size(), due);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (match_words_due.size() == 0) begin
               report_mismatch("result word with none due", 0, 0);
            end else begin
               want = match_words_due.pop_front();
               if (rsp_chan.match_found !== want.match_found)
                  report_mismatch("match_found", rsp_chan.match_found, want.match_found);
               if (rsp_chan.match_x !== want.match_x)
                  report_mismatch("match_x", rsp_chan.match_x, want.match_x);
               if (rsp_chan.match_y !== want.match_y)
                  report_mismatch("match_y", rsp_chan.match_y, want.match_y);
               if (rsp_chan.match_count !== want.match_count)
                  report_mismatch("match_count", rsp_chan.match_count, want.match_count);
               if (rsp_chan.frame_end !== want.frame_end)
                  report_mismatch("frame_end", rsp_chan.frame_end, want.frame_end);
            end
         end
      end
      words_due <= match_words_due.size();
   end

endmodule

// ===== sim/grid_2x2_pattern_match_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid 2x2 pattern match testbench
// Drives raster frames of cell words into the block under several grid sizes
// and patterns, with random stalls on both channels. A short directed part
// covers the default setup, size aliasing, colors above white and a solid
// frame; random frames follow, some with size changes in mid-frame and two
// at the largest sizes. The checker beside the block does all comparing.
// ----------------------------------------------------------------------------
module grid_2x2_pattern_match_tb;
   import gpm_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;
   localparam int CELLS_RANDOM = 1650;

   typedef enum int {FILL_FIXED, FILL_SOLID, FILL_PAIR, FILL_NOISE} fill_mode_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;
   int                    mismatches;
   int                    words_due;

   int                    send_idle_pct = 32;
   int                    take_idle_pct = 59;
   logic [CSR_DATA_W-1:0] width_raw = CSR_DATA_W'(2);
   logic [CSR_DATA_W-1:0] height_raw = CSR_DATA_W'(2);
   int                    col_pos = 0;
   int                    row_pos = 0;
   int                    frames_done = 0;
   fill_mode_type         cell_mode = FILL_FIXED;
   logic [COLOR_W-1:0]    color_a = '0;
   logic [COLOR_W-1:0]    color_b = '0;
   int                    random_cells = 0;

   gpm_req_if req_chan ();
   gpm_rsp_if rsp_chan ();

   grid_2x2_pattern_match dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   grid_2x2_pattern_match_checker match_checker (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatches       (mismatches),
      .words_due        (words_due)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= take_idle_pct);
   end

   function automatic int grid_span(input logic [CSR_DATA_W-1:0] raw, input int lim);
      if (raw < 2) return 2;
      if (raw > lim) return lim;
      return int'(raw);
   endfunction

   function automatic logic [COLOR_W-1:0] random_color();
      if ($urandom_range(0, 4) == 0) return COLOR_W'($urandom_range(5, 7));
      return COLOR_W'($urandom_range(0, 4));
   endfunction

   function automatic logic [COLOR_W-1:0] pick_cell();
      logic [COLOR_W-1:0] color;
      color = COLOR_W'($urandom_range(0, 7));
      case (cell_mode)
         FILL_FIXED: color = color_a;
         FILL_SOLID: if ($urandom_range(0, 99) < 80) color = color_a;
         FILL_PAIR:  if ($urandom_range(0, 99) < 85) color = $urandom_range(0, 1) ? color_a : color_b;
         default: ;
      endcase
      return color;
   endfunction

   // Tracks the raster position so that stimulus can end on a frame boundary.
   task automatic advance_position();
      if (col_pos >= grid_span(width_raw, MAX_WIDTH) - 1) begin
         col_pos = 0;
         if (row_pos >= grid_span(height_raw, MAX_HEIGHT) - 1) begin
            row_pos = 0;
            frames_done++;
         end else begin
            row_pos++;
         end
      end else begin
         col_pos++;
      end
   endtask

   task automatic send_cell(input logic [COLOR_W-1:0] color);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < send_idle_pct) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.cell_color <= color;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      advance_position();
   endtask

   task automatic drain_block();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_grid(input logic [CSR_DATA_W-1:0] w, input logic [CSR_DATA_W-1:0] h);
      write_reg(CSR_GRID_WIDTH, w);
      write_reg(CSR_GRID_HEIGHT, h);
      width_raw = w;
      height_raw = h;
   endtask

   task automatic set_pattern(input logic [COLOR_W-1:0] tl, input logic [COLOR_W-1:0] tr,
                              input logic [COLOR_W-1:0] bl, input logic [COLOR_W-1:0] br);
      write_reg(CSR_PAT_TOP_LEFT, {8'($urandom_range(0, 255)), tl});
      write_reg(CSR_PAT_TOP_RGHT, {8'($urandom_range(0, 255)), tr});
      write_reg(CSR_PAT_BOT_LEFT, {8'($urandom_range(0, 255)), bl});
      write_reg(CSR_PAT_BOT_RGHT, {8'($urandom_range(0, 255)), br});
   endtask

   // Sends whole frames; a size change can be made once, after mid_at cells.
   task automatic run_frames(input int frames, input int mid_at,
                             input logic [CSR_DATA_W-1:0] mid_w,
                             input logic [CSR_DATA_W-1:0] mid_h, output int sent);
      sent = 0;
      frames_done = 0;
      while (frames_done < frames) begin
         if (sent == mid_at) begin
            drain_block();
            set_grid(mid_w, mid_h);
         end
         send_cell(pick_cell());
         sent++;
      end
   endtask

   task automatic pick_pattern();
      color_a = random_color();
      color_b = random_color();
      cell_mode = fill_mode_type'($urandom_range(FILL_SOLID, FILL_NOISE));
      case (cell_mode)
         FILL_SOLID: set_pattern(color_a, color_a, color_a, color_a);
         FILL_PAIR:  set_pattern($urandom_range(0, 1) ? color_a : color_b,
                                 $urandom_range(0, 1) ? color_a : color_b,
                                 $urandom_range(0, 1) ? color_a : color_b,
                                 $urandom_range(0, 1) ? color_a : color_b);
         default:    set_pattern(COLOR_W'($urandom_range(0, 7)), COLOR_W'($urandom_range(0, 7)),
                                 COLOR_W'($urandom_range(0, 7)), COLOR_W'($urandom_range(0, 7)));
      endcase
   endtask

   initial begin
      logic [COLOR_W-1:0]    odd_frame [6];
      logic [CSR_DATA_W-1:0] w;
      logic [CSR_DATA_W-1:0] h;
      logic [CSR_DATA_W-1:0] mid_w;
      logic [CSR_DATA_W-1:0] mid_h;
      int                    phase_no;
      int                    span;
      int                    mid_at;
      int                    sent;

      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = CSR_GRID_WIDTH;
      csr_write_data = '0;
      req_chan.valid = 1'b0;
      req_chan.cell_color = '0;
      rsp_chan.ready = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset setup: a 2x2 frame of red matches the all-red pattern once.
      cell_mode = FILL_FIXED;
      color_a = 3'd0;
      run_frames(1, -1, '0, '0, sent);

      // Sizes below two alias to two.
      drain_block();
      set_grid(CSR_DATA_W'(0), CSR_DATA_W'(1));
      set_pattern(3'd4, 3'd4, 3'd4, 3'd4);
      color_a = 3'd4;
      run_frames(1, -1, '0, '0, sent);

      // Colors above white, and writes to unused indexes that must change nothing.
      drain_block();
      write_reg(CSR_SPARE_A, '1);
      write_reg(CSR_SPARE_B, '1);
      set_grid(CSR_DATA_W'(3), CSR_DATA_W'(2));
      set_pattern(3'd7, 3'd5, 3'd6, 3'd7);
      odd_frame = '{3'd0, 3'd7, 3'd5, 3'd0, 3'd6, 3'd7};
      foreach (odd_frame[i]) send_cell(odd_frame[i]);

      // Every window of a solid 3x3 frame matches.
      drain_block();
      set_grid(CSR_DATA_W'(3), CSR_DATA_W'(3));
      set_pattern(3'd3, 3'd3, 3'd3, 3'd3);
      color_a = 3'd3;
      run_frames(1, -1, '0, '0, sent);

      phase_no = 0;
      while (random_cells < CELLS_RANDOM || phase_no < 10) begin
         if (random_cells < CELLS_RANDOM / 3) begin
            send_idle_pct = 32;
            take_idle_pct = 59;
         end else if (random_cells < 2 * CELLS_RANDOM / 3) begin
            send_idle_pct = 59;
            take_idle_pct = 32;
         end else begin
            send_idle_pct = 0;
            take_idle_pct = 0;
         end
         drain_block();
         pick_pattern();
         if (phase_no == 3) begin
            // Widest row, then cut short by a narrower width in the second row.
            set_grid(CSR_DATA_W'(MAX_WIDTH), CSR_DATA_W'(2));
            run_frames(1, MAX_WIDTH + 8, CSR_DATA_W'(1), CSR_DATA_W'(2), sent);
         end else if (phase_no == 9) begin
            // Tallest frame, ended early by a lower height.
            set_grid(CSR_DATA_W'(2), '1);
            run_frames(1, 24, CSR_DATA_W'(2), CSR_DATA_W'(3), sent);
         end else begin
            w = ($urandom_range(0, 9) == 0) ? CSR_DATA_W'($urandom_range(0, 1)) :
                                              CSR_DATA_W'($urandom_range(2, 12));
            h = ($urandom_range(0, 9) == 0) ? CSR_DATA_W'($urandom_range(0, 1)) :
                                              CSR_DATA_W'($urandom_range(2, 8));
            set_grid(w, h);
            span = grid_span(w, MAX_WIDTH);
            mid_at = -1;
            if ($urandom_range(0, 3) == 0) begin
               mid_at = $urandom_range(1, span * grid_span(h, MAX_HEIGHT) - 1);
            end
            mid_w = CSR_DATA_W'($urandom_range(0, span));
            mid_h = CSR_DATA_W'($urandom_range(0, 9));
            run_frames($urandom_range(1, 3), mid_at, mid_w, mid_h, sent);
         end
         random_cells += sent;
         phase_no++;
      end

      drain_block();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && words_due == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("FAIL");
      $finish;
   end

endmodule

// ===== grid_2x2_pattern_match.f =====
+incdir+hdl
hdl/gpm_pkg.sv
hdl/gpm_if.sv
hdl/gpm_csr.sv
hdl/gpm_line_buffer.sv
hdl/grid_2x2_pattern_match.sv
sim/grid_2x2_pattern_match_checker.sv
sim/grid_2x2_pattern_match_tb.sv
